/* rtl/mpts_pkg.sv */
`timescale 1ns / 1ps
package mpts_pkg;

    localparam int SLOT_W   = 4;
    localparam int TIME_W   = 16;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W    = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_POLICY  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_QUANTUM = 1'b1;

    localparam logic [TIME_W-1:0] QUANTUM_RESET = 16'd500;

    localparam logic OP_ARRIVE = 1'b0;
    localparam logic OP_TICK   = 1'b1;

    typedef enum logic [1:0] {
        POL_FIFO = 2'd0,
        POL_RR   = 2'd1,
        POL_SJF  = 2'd2,
        POL_SRTF = 2'd3
    } pol_t;

    typedef struct packed {
        logic              op;
        logic [SLOT_W-1:0] task_slot;
        logic [TIME_W-1:0] burst_length;
    } in_word_t;

    typedef struct packed {
        logic              ran_valid;
        logic [SLOT_W-1:0] ran_slot;
        logic              finished;
    } out_word_t;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic scan_en;
        logic pick;
        logic commit;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic is_tick;
        logic scan_last;
        logic out_free;
    } sts_t;

endpackage

/* rtl/multi_policy_tick_task_scheduler.sv */
`timescale 1ns / 1ps
// Task table scheduler. An arrival word (op 0) loads a free slot with a burst
// length; a tick word (op 1) runs one time unit of one task under the policy
// register (fifo, round robin with quantum, shortest job first, preemptive
// shortest remaining) and returns one result word naming the slot that ran and
// whether it finished. Arrivals are taken from idle and give no result. A tick
// runs through these steps: accept, a scan of the remaining-time memory one
// slot per cycle through its single read port, a drain of the read, the pick
// of the task, and the write back that loads the output register, which waits
// while the output is stalled. Configuration is written through the plain write
// port while the block is idle: the user must keep to this, the block does not enforce it.
module multi_policy_tick_task_scheduler #(
    parameter int SLOTS     = 16,
    parameter int TIME_BITS = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // input word channel
    input  logic                           in_valid,
    output logic                           in_stall,
    input  mpts_pkg::in_word_t             in_data,
    // result word channel
    output logic                           out_valid,
    input  logic                           out_stall,
    output mpts_pkg::out_word_t            out_data,
    // configuration writes
    input  logic                           cfg_wr_en,
    input  logic [mpts_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [mpts_pkg::CFG_W-1:0]     cfg_data
);
    import mpts_pkg::*;

    // command and status between sequencer and datapath
    cmd_t cmd;
    sts_t sts;

    // sequencer: idle, scan, drain, pick, update
    mpts_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    // task table, scan registers, config and output register
    mpts_dp #(
        .SLOTS     (SLOTS),
        .TIME_BITS (TIME_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

/* rtl/mpts_ram.sv */
`timescale 1ns / 1ps
module mpts_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/mpts_ctrl.sv */
`timescale 1ns / 1ps
module mpts_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    input  mpts_pkg::sts_t sts,
    output mpts_pkg::cmd_t cmd
);
    import mpts_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_SCAN = 5'b00010,
        ST_LAST = 5'b00100,
        ST_PICK = 5'b01000,
        ST_UPD  = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    if (sts.is_tick)
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                cmd.scan_en = 1'b1;
                if (sts.scan_last)
                begin
                    state_next = ST_LAST;
                end
            end
            ST_LAST:
            begin
                state_next = ST_PICK;
            end
            ST_PICK:
            begin
                cmd.pick   = 1'b1;
                state_next = ST_UPD;
            end
            ST_UPD:
            begin
                if (sts.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // a tick only starts from idle, so scan and commit never overlap an accept
    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        $countones({cmd.accept, cmd.scan_en, cmd.pick, cmd.commit}) <= 1)
        else $error("controller issued overlapping commands");
    a_pick_then_upd: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pick |=> (state_reg == ST_UPD))
        else $error("pick not followed by update");
    a_scan_from_tick: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.accept && !sts.is_tick) |=> (state_reg == ST_IDLE))
        else $error("arrival started a scan");

endmodule

/* rtl/mpts_dp.sv */
`timescale 1ns / 1ps
module mpts_dp #(
    parameter int SLOTS     = 16,
    parameter int TIME_BITS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  mpts_pkg::in_word_t                  in_data,
    output logic                                out_valid,
    input  logic                                out_stall,
    output mpts_pkg::out_word_t                 out_data,
    input  logic                                cfg_wr_en,
    input  logic [mpts_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [mpts_pkg::CFG_W-1:0]          cfg_data,
    input  mpts_pkg::cmd_t                      cmd,
    output mpts_pkg::sts_t                      sts
);
    import mpts_pkg::*;

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int RW = $clog2(SLOTS + 1);
    localparam logic [31:0] TMAX = 32'((64'd1 << TIME_BITS) - 64'd1);
    localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);

    // config
    pol_t              policy_reg;
    logic [TIME_W-1:0] quantum_reg;

    // task table
    logic [SLOTS-1:0]  active_reg, active_next;
    logic [IW-1:0]     rank_reg [SLOTS];
    logic [IW-1:0]     rank_next [SLOTS];
    logic [RW-1:0]     act_cnt_reg, act_cnt_next;
    logic              cur_v_reg, cur_v_next;
    logic [IW-1:0]     cur_reg, cur_next;
    logic              prev_v_reg, prev_v_next;
    logic [IW-1:0]     prev_reg, prev_next;
    logic [TIME_W-1:0] slice_reg, slice_next;

    // scan
    logic [IW-1:0]     cnt_reg;
    logic              sv_reg;
    logic [IW-1:0]     sidx_reg;
    logic              best_v_reg;
    logic [IW-1:0]     best_reg;
    logic [TIME_BITS-1:0] best_t_reg;
    logic              rlo_v_reg, rhi_v_reg, fifo_v_reg;
    logic [IW-1:0]     rlo_reg, rhi_reg, fifo_reg;
    logic              ch_v_reg;
    logic [IW-1:0]     ch_reg;

    // output
    logic              out_valid_reg;
    out_word_t         out_data_reg;

    // ram
    logic                 ram_we;
    logic [IW-1:0]        ram_waddr, ram_raddr;
    logic [TIME_BITS-1:0] ram_wdata, ram_rdata;

    // arrival decode
    logic                 arr_ok;
    logic [IW-1:0]        aslot;
    logic [31:0]          burst_sat;

    // choice
    logic                 cur_ok;
    logic                 ch_v;
    logic [IW-1:0]        ch;
    logic [IW:0]          rot_start;

    // commit
    logic [TIME_BITS-1:0] t_dec;
    logic [TIME_W-1:0]    slice_eff, slice_inc, q_eff;
    logic                 fin;
    logic [SLOTS-1:0]     ch_mask;

    assign aslot     = IW'(in_data.task_slot);
    assign arr_ok    = (in_data.burst_length != '0)
                    && ({28'd0, in_data.task_slot} < 32'(SLOTS))
                    && !active_reg[aslot];
    assign burst_sat = ({16'd0, in_data.burst_length} > TMAX) ? TMAX
                     : {16'd0, in_data.burst_length};

    assign cur_ok    = cur_v_reg && active_reg[cur_reg];
    assign rot_start = prev_v_reg ? ({1'b0, prev_reg} + 1'b1) : '0;

    always_comb
    begin
        ch_v = 1'b0;
        ch   = '0;
        case (policy_reg)
            POL_FIFO:
            begin
                ch_v = fifo_v_reg;
                ch   = fifo_reg;
            end
            POL_RR:
            begin
                if (cur_ok)
                begin
                    ch_v = 1'b1;
                    ch   = cur_reg;
                end
                else
                begin
                    ch_v = rlo_v_reg;
                    ch   = rhi_v_reg ? rhi_reg : rlo_reg;
                end
            end
            POL_SJF:
            begin
                ch_v = cur_ok || best_v_reg;
                ch   = cur_ok ? cur_reg : best_reg;
            end
            default:
            begin
                ch_v = best_v_reg;
                ch   = best_reg;
            end
        endcase
    end

    // ram ports
    always_comb
    begin
        if (cmd.scan_en)
        begin
            ram_raddr = cnt_reg;
        end
        else if (cmd.pick)
        begin
            ram_raddr = ch;
        end
        else
        begin
            ram_raddr = ch_reg;
        end
        ram_we    = 1'b0;
        ram_waddr = ch_reg;
        ram_wdata = t_dec;
        if (cmd.accept && in_data.op == OP_ARRIVE && arr_ok)
        begin
            ram_we    = 1'b1;
            ram_waddr = aslot;
            ram_wdata = TIME_BITS'(burst_sat);
        end
        else if (cmd.commit && ch_v_reg)
        begin
            ram_we = 1'b1;
        end
    end

    mpts_ram #(
        .WIDTH (TIME_BITS),
        .DEPTH (SLOTS)
    ) u_time_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // tick update
    assign t_dec     = ram_rdata - 1'b1;
    assign fin       = (t_dec == '0);
    assign slice_eff = (cur_v_reg && cur_reg == ch_reg) ? slice_reg : '0;
    assign slice_inc = (slice_eff == '1) ? slice_eff : slice_eff + 1'b1;
    assign q_eff     = (quantum_reg == '0) ? TIME_W'(1) : quantum_reg;
    assign ch_mask   = SLOTS'(1) << ch_reg;

    always_comb
    begin
        active_next  = active_reg;
        rank_next    = rank_reg;
        act_cnt_next = act_cnt_reg;
        cur_v_next   = cur_v_reg;
        cur_next     = cur_reg;
        prev_v_next  = prev_v_reg;
        prev_next    = prev_reg;
        slice_next   = slice_reg;
        if (cmd.accept && in_data.op == OP_ARRIVE && arr_ok)
        begin
            active_next[aslot] = 1'b1;
            rank_next[aslot]   = IW'(act_cnt_reg);
            act_cnt_next       = act_cnt_reg + 1'b1;
        end
        else if (cmd.commit && ch_v_reg)
        begin
            if (fin)
            begin
                active_next[ch_reg] = 1'b0;
                for (int i = 0; i < SLOTS; i++)
                begin
                    if (active_reg[i] && rank_reg[i] > rank_reg[ch_reg])
                    begin
                        rank_next[i] = rank_reg[i] - 1'b1;
                    end
                end
                act_cnt_next = act_cnt_reg - 1'b1;
                prev_v_next  = 1'b1;
                prev_next    = ch_reg;
                cur_v_next   = 1'b0;
                slice_next   = '0;
            end
            else if (policy_reg == POL_RR && slice_inc >= q_eff)
            begin
                prev_v_next = 1'b1;
                prev_next   = ch_reg;
                slice_next  = '0;
                // nobody else waiting: the same task keeps the processor
                cur_v_next  = ((active_reg & ~ch_mask) == '0);
                cur_next    = ch_reg;
            end
            else
            begin
                cur_v_next = 1'b1;
                cur_next   = ch_reg;
                slice_next = slice_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            policy_reg    <= POL_FIFO;
            quantum_reg   <= QUANTUM_RESET;
            active_reg    <= '0;
            act_cnt_reg   <= '0;
            cur_v_reg     <= 1'b0;
            prev_v_reg    <= 1'b0;
            slice_reg     <= '0;
            cnt_reg       <= '0;
            sv_reg        <= 1'b0;
            best_v_reg    <= 1'b0;
            rlo_v_reg     <= 1'b0;
            rhi_v_reg     <= 1'b0;
            fifo_v_reg    <= 1'b0;
            ch_v_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                unique case (cfg_index)
                    CFG_POLICY:  policy_reg  <= pol_t'(cfg_data[1:0]);
                    CFG_QUANTUM: quantum_reg <= cfg_data[TIME_W-1:0];
                    default: ;
                endcase
            end
            active_reg  <= active_next;
            act_cnt_reg <= act_cnt_next;
            cur_v_reg   <= cur_v_next;
            prev_v_reg  <= prev_v_next;
            slice_reg   <= slice_next;

            sv_reg <= cmd.scan_en;
            if (cmd.accept)
            begin
                cnt_reg    <= '0;
                best_v_reg <= 1'b0;
                rlo_v_reg  <= 1'b0;
                rhi_v_reg  <= 1'b0;
                fifo_v_reg <= 1'b0;
            end
            else
            begin
                if (cmd.scan_en && cnt_reg != LAST_IDX)
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
                if (sv_reg && active_reg[sidx_reg])
                begin
                    if (!best_v_reg || ram_rdata < best_t_reg)
                    begin
                        best_v_reg <= 1'b1;
                    end
                    if (!rlo_v_reg)
                    begin
                        rlo_v_reg <= 1'b1;
                    end
                    if (!rhi_v_reg && {1'b0, sidx_reg} >= rot_start)
                    begin
                        rhi_v_reg <= 1'b1;
                    end
                    if (rank_reg[sidx_reg] == '0)
                    begin
                        fifo_v_reg <= 1'b1;
                    end
                end
            end
            if (cmd.pick)
            begin
                ch_v_reg <= ch_v;
            end

            if (cmd.commit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        rank_reg <= rank_next;
        cur_reg  <= cur_next;
        prev_reg <= prev_next;
        sidx_reg <= cnt_reg;
        if (sv_reg && active_reg[sidx_reg] && !cmd.accept)
        begin
            if (!best_v_reg || ram_rdata < best_t_reg)
            begin
                best_reg   <= sidx_reg;
                best_t_reg <= ram_rdata;
            end
            if (!rlo_v_reg)
            begin
                rlo_reg <= sidx_reg;
            end
            if (!rhi_v_reg && {1'b0, sidx_reg} >= rot_start)
            begin
                rhi_reg <= sidx_reg;
            end
            if (rank_reg[sidx_reg] == '0)
            begin
                fifo_reg <= sidx_reg;
            end
        end
        if (cmd.pick)
        begin
            ch_reg <= ch;
        end
        if (cmd.commit)
        begin
            out_data_reg.ran_valid <= ch_v_reg;
            out_data_reg.ran_slot  <= ch_v_reg ? SLOT_W'(ch_reg) : '0;
            out_data_reg.finished  <= ch_v_reg && fin;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign sts.is_tick   = (in_data.op == OP_TICK);
    assign sts.scan_last = (cnt_reg == LAST_IDX);
    assign sts.out_free  = !out_valid_reg || !out_stall;

    a_cnt_match: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(active_reg) == int'(act_cnt_reg))
        else $error("active count out of step with active slots");
    a_cur_active: assert property (@(posedge clk) disable iff (!rst_n)
        cur_v_reg |-> active_reg[cur_reg])
        else $error("current task is not loaded");
    a_fin_ran: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_data_reg.finished) |-> out_data_reg.ran_valid)
        else $error("finished reported on idle tick");
    a_fin_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.commit && ch_v_reg && fin) |=> !active_reg[$past(ch_reg)])
        else $error("finished task still active");

endmodule
